FILE: rtl/core/cs_pkg.sv
package cs_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // result queue depth; must hold at least two beats
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_BLOCK  = 3'd2,
        MODE_BSTAR  = 3'd3,
        MODE_HASH   = 3'd4,
        MODE_STR    = 3'd5,
        MODE_ESC    = 3'd6
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] kept_byte;
        logic       byte_present;
        logic       run_last;
        logic       text_done;
    } t_out_beat;

    // results of one item, handed to the queue together in the same cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_out_beat  r0;
        t_out_beat  r1;
    } t_push;

endpackage

FILE: rtl/core/cs_lexer.sv
module cs_lexer
    import cs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_beat i_data,
    input  logic     i_room,
    output t_push    o_push
);

    logic     r_in_valid;
    t_in_beat r_in;
    t_mode    r_mode;
    t_mode    n_mode;
    t_mode    step_mode;
    logic     adv;
    logic     fin;
    logic [7:0] b;
    logic     pre_slash;
    logic     put_b;
    logic     post_slash;
    logic [1:0] n_res;
    logic [1:0] push_cnt;
    logic [7:0] res0;
    logic [7:0] res1;

    function automatic t_mode normal_next(logic [7:0] c);
        t_mode m;
        if (c == CH_SLASH) begin
            m = MODE_SLASH;
        end else if (c == CH_HASH) begin
            m = MODE_HASH;
        end else if (c == CH_QUOTE) begin
            m = MODE_STR;
        end else begin
            m = MODE_NORMAL;
        end
        return m;
    endfunction

    assign adv     = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign b       = r_in.text_byte;
    assign fin     = r_in.final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (adv) begin
            r_mode <= n_mode;
        end
    end

    // next state
    always_comb begin
        case (r_mode)
            MODE_SLASH: begin
                step_mode = (b == CH_STAR) ? MODE_BLOCK : normal_next(b);
            end
            MODE_BLOCK, MODE_BSTAR: begin
                if (r_mode == MODE_BSTAR && b == CH_SLASH) begin
                    step_mode = MODE_NORMAL;
                end else if (b == CH_STAR) begin
                    step_mode = MODE_BSTAR;
                end else begin
                    step_mode = MODE_BLOCK;
                end
            end
            MODE_HASH: begin
                step_mode = (b == CH_NL) ? MODE_NORMAL : MODE_HASH;
            end
            MODE_STR: begin
                if (b == CH_QUOTE) begin
                    step_mode = MODE_NORMAL;
                end else if (b == CH_BSLASH) begin
                    step_mode = MODE_ESC;
                end else begin
                    step_mode = MODE_STR;
                end
            end
            MODE_ESC: begin
                step_mode = MODE_STR;
            end
            default: begin
                step_mode = normal_next(b);
            end
        endcase
        n_mode = fin ? MODE_NORMAL : step_mode;
    end

    // outputs: held slash, then the byte itself, then a slash held at the end
    always_comb begin
        pre_slash = 1'b0;
        put_b     = 1'b0;
        case (r_mode)
            MODE_SLASH: begin
                pre_slash = (b != CH_STAR);
                put_b     = (b != CH_STAR) && (b != CH_SLASH) && (b != CH_HASH);
            end
            MODE_BLOCK, MODE_BSTAR, MODE_HASH: begin
                put_b = (b == CH_NL);
            end
            MODE_STR, MODE_ESC: begin
                put_b = 1'b1;
            end
            default: begin
                put_b = (b != CH_SLASH) && (b != CH_HASH);
            end
        endcase
        post_slash = fin && (step_mode == MODE_SLASH);

        n_res = {1'b0, pre_slash} + {1'b0, put_b} + {1'b0, post_slash};
        res0  = pre_slash ? CH_SLASH : (put_b ? b : CH_SLASH);
        res1  = (pre_slash && put_b) ? b : CH_SLASH;

        if (!adv) begin
            push_cnt = 2'd0;
        end else if (n_res == 2'd0) begin
            push_cnt = {1'b0, fin};
        end else begin
            push_cnt = n_res;
        end

        o_push.cnt             = push_cnt;
        o_push.r0.kept_byte    = (n_res == 2'd0) ? 8'd0 : res0;
        o_push.r0.byte_present = (n_res != 2'd0);
        o_push.r0.run_last     = (push_cnt == 2'd1);
        o_push.r0.text_done    = fin && (push_cnt == 2'd1);
        o_push.r1.kept_byte    = res1;
        o_push.r1.byte_present = 1'b1;
        o_push.r1.run_last     = 1'b1;
        o_push.r1.text_done    = fin;
    end

    a_final_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && fin |-> o_push.cnt != 2'd0)
        else $error("final beat produced no result");

    a_final_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && fin |=> r_mode == MODE_NORMAL)
        else $error("mode not normal after final beat");

    a_at_most_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> o_push.cnt != 2'd3)
        else $error("more than two results for one beat");

endmodule

FILE: rtl/core/cs_outq.sv
module cs_outq
    import cs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    t_out_beat        r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp;
    logic [OQ_AW-1:0] r_rp;
    logic [OQ_CW-1:0] r_count;
    logic [OQ_CW-1:0] n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    // room for two results, without looking at this cycle's pop
    assign o_room  = (r_count <= OQ_CW'(OQ_DEPTH - 2));
    assign n_count = r_count + OQ_CW'(i_push.cnt) - OQ_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + OQ_AW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + OQ_AW'(i_push.cnt);
            r_rp    <= r_rp + OQ_AW'(pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CW'(OQ_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_room)
        else $error("push without room");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.text_done |-> o_data.run_last)
        else $error("end of text beat not marked last");

endmodule

FILE: rtl/core/comment_stripper_top.sv
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-------------------------------------
// input    | in  | i_valid / o_stall  | i_data : t_in_beat (byte, final)
// output   | out | o_valid / i_stall  | o_data : t_out_beat (byte, flags)
//
// One input beat per cycle while o_stall is low. A beat that yields two
// results holds the output for two beats; a four-entry result queue absorbs
// that, so the input side stalls only when the queue holds more than two
// results. An accepted beat goes through the input register, then the queue.
// Reset (synchronous, active low) clears the lexer mode, the input register
// valid bit and the queue; payload registers are not reset.
module comment_stripper_top
    import cs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    t_push push;
    logic  room;

    cs_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_room  (room),
        .o_push  (push)
    );

    cs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
